/* hdl/window_level_to_gray8_defines.svh */
// ----------------------------------------------------------------------------
// window_level_to_gray8 assertion macros
// Shared concurrent assertion forms for the window/level gray mapper.
// ----------------------------------------------------------------------------
`ifndef WINDOW_LEVEL_TO_GRAY8_DEFINES_SVH
`define WINDOW_LEVEL_TO_GRAY8_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define WL2G_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WL2G_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wl2g_pkg.sv */
// ----------------------------------------------------------------------------
// wl2g_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wl2g_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEVEL_BITS      = 16;
    localparam int WIDTH_BITS      = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int GRAY_BITS       = 8;
    localparam int QUOT_BITS       = 8;
    localparam int CNT_BITS        = $clog2(QUOT_BITS);

    localparam logic [GRAY_BITS-1:0] GRAY_MIN = '0;
    localparam logic [GRAY_BITS-1:0] GRAY_MAX = '1;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEVEL = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_WIDTH = 1'b1;

    // input action codes
    localparam logic ACT_GATHER  = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    typedef struct packed {
        logic take_gather;   // gather request accepted
        logic take_convert;  // convert request accepted
        logic eval;          // classify sample, set up divide
        logic div_step;      // one restoring divide step
        logic load_out;      // move result into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip_div;      // sample clamps to 0 or 255
    } dp_status_t;

endpackage

`default_nettype wire

/* hdl/wl2g_ctrl.sv */
// ----------------------------------------------------------------------------
// wl2g_ctrl
// Sequencer for the gray mapper: handshakes, divide step count, output flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "window_level_to_gray8_defines.svh"

module wl2g_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_action,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire wl2g_pkg::dp_status_t  status,
    output wl2g_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [wl2g_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            accept;
    logic                            out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == wl2g_pkg::ACT_CONVERT) begin
                        cmd.take_convert = 1'b1;
                        state_next       = ST_EVAL;
                    end else begin
                        cmd.take_gather = 1'b1;
                    end
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                cnt_next = wl2g_pkg::CNT_BITS'(wl2g_pkg::QUOT_BITS - 1);
                if (status.skip_div) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---- assertions ----
    `WL2G_ASSERT_NEXT(a_convert_to_eval, aclk, aresetn,
        accept && (s_action == wl2g_pkg::ACT_CONVERT), state_reg == ST_EVAL,
        "convert request did not start evaluation")
    `WL2G_ASSERT_NEXT(a_div_ends, aclk, aresetn,
        (state_reg == ST_DIV) && (cnt_reg == '0), state_reg == ST_DONE,
        "divider overran its step count")
    `WL2G_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        (state_reg == ST_DONE) && out_free, out_valid_reg && (state_reg == ST_IDLE),
        "finished result not moved to output register")

endmodule

`default_nettype wire

/* hdl/wl2g_datapath.sv */
// ----------------------------------------------------------------------------
// wl2g_datapath
// Window registers, running min/max, window bounds and restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wl2g_datapath #(
    parameter int SAMPLE_BITS = wl2g_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [wl2g_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [wl2g_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  wire logic signed [SAMPLE_BITS-1:0]         s_sample,
    input  wire logic                                  s_last,
    input  wire wl2g_pkg::ctrl_cmd_t                   cmd,
    output wl2g_pkg::dp_status_t                       status,
    output logic [wl2g_pkg::GRAY_BITS-1:0]             m_gray,
    output logic                                       m_last_res
);

    // doubled bounds: wide enough for 2*level +/- width and 2*sample
    localparam int EXT = (SAMPLE_BITS + 1 > 18) ? SAMPLE_BITS + 1 : 18;
    localparam int VW  = EXT + 1;
    localparam int DW  = VW - 1;          // positive span x2-lo2, hi2-lo2
    localparam int NW  = DW + 9;          // 510*diff + d

    logic signed [wl2g_pkg::LEVEL_BITS-1:0] level_reg;
    logic        [wl2g_pkg::WIDTH_BITS-1:0] width_reg;
    logic signed [SAMPLE_BITS-1:0]          range_low_reg, range_high_reg;
    logic                                   range_seen_reg;
    logic                                   restart_reg;

    logic signed [VW-1:0] lo2_reg, hi2_reg, x2_reg;
    logic signed [VW-1:0] lo2_next, hi2_next, x2_next;
    logic                 last_reg;

    logic [NW-1:0]                     rem_reg, dv_reg;
    logic [wl2g_pkg::GRAY_BITS-1:0]    q_reg;
    logic [wl2g_pkg::GRAY_BITS-1:0]    gray_reg;
    logic                              last_out_reg;

    logic signed [VW-1:0] level_x, width_x, span_x, diff_x;
    logic        [DW-1:0] span, diff;
    logic        [NW-1:0] num;
    logic                 below, above;
    logic                 auto_mode;
    logic                 fresh;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            width_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == wl2g_pkg::REG_WINDOW_LEVEL) begin
                level_reg <= cfg_wdata[wl2g_pkg::LEVEL_BITS-1:0];
            end
            if (cfg_index == wl2g_pkg::REG_WINDOW_WIDTH) begin
                width_reg <= cfg_wdata[wl2g_pkg::WIDTH_BITS-1:0];
            end
        end
    end

    // running min/max of the gather pass
    assign fresh = restart_reg || !range_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= '0;
            range_high_reg <= '0;
            range_seen_reg <= 1'b0;
            restart_reg    <= 1'b1;
        end else if (cmd.take_gather) begin
            if (fresh || (s_sample < range_low_reg)) begin
                range_low_reg <= s_sample;
            end
            if (fresh || (s_sample > range_high_reg)) begin
                range_high_reg <= s_sample;
            end
            range_seen_reg <= 1'b1;
            restart_reg    <= s_last;
        end else if (cmd.take_convert) begin
            restart_reg <= 1'b1;
        end
    end

    // window bounds in half units
    assign auto_mode = (level_reg == '0) && (width_reg == '0);
    assign level_x   = {{(VW-wl2g_pkg::LEVEL_BITS){level_reg[wl2g_pkg::LEVEL_BITS-1]}},
                        level_reg};
    assign width_x   = {{(VW-wl2g_pkg::WIDTH_BITS){1'b0}}, width_reg};

    always_comb begin
        x2_next = {{(VW-SAMPLE_BITS){s_sample[SAMPLE_BITS-1]}}, s_sample} <<< 1;
        if (auto_mode) begin
            lo2_next = {{(VW-SAMPLE_BITS){range_low_reg[SAMPLE_BITS-1]}},
                        range_low_reg} <<< 1;
            hi2_next = {{(VW-SAMPLE_BITS){range_high_reg[SAMPLE_BITS-1]}},
                        range_high_reg} <<< 1;
        end else begin
            lo2_next = (level_x <<< 1) - width_x;
            hi2_next = (level_x <<< 1) + width_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_convert) begin
            lo2_reg  <= lo2_next;
            hi2_reg  <= hi2_next;
            x2_reg   <= x2_next;
            last_reg <= s_last;
        end
    end

    // classify and set up the divide
    assign below  = (x2_reg <= lo2_reg);
    assign above  = (x2_reg > hi2_reg);
    assign span_x = hi2_reg - lo2_reg;
    assign diff_x = x2_reg - lo2_reg;
    assign span   = span_x[DW-1:0];
    assign diff   = diff_x[DW-1:0];
    // 510*diff + span; never above 511*span for a sample inside the window
    assign num    = {diff, 9'b0} - {8'b0, diff, 1'b0} + {9'b0, span};

    assign status.skip_div = below || above;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            rem_reg <= num;
            dv_reg  <= {1'b0, span, 8'b0};
            if (below) begin
                q_reg <= wl2g_pkg::GRAY_MIN;
            end else if (above) begin
                q_reg <= wl2g_pkg::GRAY_MAX;
            end else begin
                q_reg <= '0;
            end
        end else if (cmd.div_step) begin
            if (rem_reg >= dv_reg) begin
                rem_reg <= rem_reg - dv_reg;
                q_reg   <= {q_reg[wl2g_pkg::GRAY_BITS-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[wl2g_pkg::GRAY_BITS-2:0], 1'b0};
            end
            dv_reg <= dv_reg >> 1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            gray_reg     <= q_reg;
            last_out_reg <= last_reg;
        end
    end

    assign m_gray     = gray_reg;
    assign m_last_res = last_out_reg;

endmodule

`default_nettype wire

/* hdl/window_level_to_gray8.sv */
// Gather requests are taken one per cycle while idle and may follow back to
// back. A convert request is evaluated and, unless it clamps to 0 or 255,
// passes through the 8-step restoring divider; its result then waits until
// the output register is free. The next request is taken once the result sits in
// the output register. Reset (aresetn low, synchronous) clears the window
// registers, the gathered range and the output valid flag.
// ----------------------------------------------------------------------------
// window_level_to_gray8
// Window/level mapping of signed samples to 8-bit gray, with an auto range
// taken from a gather pass when level and width are both zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module window_level_to_gray8 #(
    parameter int SAMPLE_BITS = wl2g_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [wl2g_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [wl2g_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // sample request channel
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_action,
    input  wire logic signed [SAMPLE_BITS-1:0]         s_sample,
    input  wire logic                                  s_last,
    // gray result channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [wl2g_pkg::GRAY_BITS-1:0]             m_gray,
    output logic                                       m_last_res
);

    // Command and status between sequencer and datapath.
    //   take_gather / take_convert: request accepted in IDLE
    //   eval: compare 2x against the doubled bounds, load dividend 510*(x2-lo2)+d
    //   div_step: one quotient bit of (510*(x2-lo2)+d) / (2d)
    //   load_out: copy quotient and last flag into the output register
    wl2g_pkg::ctrl_cmd_t  cmd;
    wl2g_pkg::dp_status_t status;

    // Sequencer: owns the handshakes and the output valid flag, so a finished
    // result can wait downstream while the next request is accepted.
    wl2g_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: window registers, gathered min/max, bounds, serial divider and
    // the output payload register.
    wl2g_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_sample   (s_sample),
        .s_last     (s_last),
        .cmd        (cmd),
        .status     (status),
        .m_gray     (m_gray),
        .m_last_res (m_last_res)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for window_level_to_gray8. A directed table covers the
// reset state, extreme windows, empty windows and the gather-pass restarts.
// Random images then run through gather and convert passes under three
// idling patterns. Every result is checked against an in-bench model of the
// window mapping, or against a gray typed into the directed table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int SB             = wl2g_pkg::SAMPLE_BITS_DEF;
    localparam int LB             = wl2g_pkg::LEVEL_BITS;
    localparam int WB             = wl2g_pkg::WIDTH_BITS;
    localparam int GB             = wl2g_pkg::GRAY_BITS;
    // quiet margin before touching registers once all grays are back
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 425;

    typedef struct packed {
        logic [GB-1:0] gray;
        logic          last;
    } gray_res_t;

    // directed table: either a request or a window (level, width) change
    typedef enum logic {ROW_REQ, ROW_WINDOW} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic          act;
        logic [SB-1:0] val;     // sample, or level for a window row
        logic          lst;
        logic [WB-1:0] wid;
        logic          pinned;  // gray typed in below, not predicted
        logic [GB-1:0] gray;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                                aclk       = 1'b0;
    logic                                aresetn    = 1'b0;
    logic                                cfg_we     = 1'b0;
    logic [wl2g_pkg::CFG_INDEX_BITS-1:0] cfg_index  = wl2g_pkg::REG_WINDOW_LEVEL;
    logic [wl2g_pkg::CFG_DATA_BITS-1:0]  cfg_wdata  = '0;
    logic                                s_valid    = 1'b0;
    logic                                s_ready;
    logic                                s_action   = wl2g_pkg::ACT_GATHER;
    logic signed [SB-1:0]                s_sample   = '0;
    logic                                s_last     = 1'b0;
    logic                                m_valid;
    logic                                m_ready    = 1'b0;
    logic [GB-1:0]                       m_gray;
    logic                                m_last_res;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    window_level_to_gray8 #(.SAMPLE_BITS(SB)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_sample   (s_sample),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_gray     (m_gray),
        .m_last_res (m_last_res)
    );

    // ------------------------------------------------------------------------
    // Mapping model: window registers, gathered range and pass restart flag.
    // ------------------------------------------------------------------------
    logic signed [LB-1:0] win_level    = '0;
    logic [WB-1:0]        win_width    = '0;
    logic signed [SB-1:0] rng_lo       = '0;
    logic signed [SB-1:0] rng_hi       = '0;
    logic                 range_valid  = 1'b0;
    logic                 restart_pass = 1'b1;

    gray_res_t gray_due [$];   // grays owed by the DUT, oldest first
    gray_res_t got_due;
    int        fails      = 0;
    int        items_sent = 0;
    int        idle_pct   = 0;  // sender gap odds, percent per cycle
    int        stall_pct  = 0;  // receiver stall odds, percent per cycle
    int        quiet      = 0;

    // Updates the model for one accepted request; returns the gray owed, if any.
    function automatic void map_sample(input logic act, input logic signed [SB-1:0] smp,
                                       input logic lst, output logic has_res,
                                       output gray_res_t res);
        longint lo2, hi2, x2, d, num, q, lvl, wid;
        res     = '0;
        has_res = 1'b0;
        if (act == wl2g_pkg::ACT_GATHER) begin
            // first gather of a pass opens a fresh min/max
            if (restart_pass || !range_valid) begin
                rng_lo = smp;
                rng_hi = smp;
            end else begin
                if (smp < rng_lo) rng_lo = smp;
                if (smp > rng_hi) rng_hi = smp;
            end
            range_valid  = 1'b1;
            restart_pass = lst;
            return;
        end
        restart_pass = 1'b1;
        lvl = longint'(win_level);
        wid = longint'(win_width);
        // bounds are held in half units so odd widths stay exact
        if (lvl == 0 && wid == 0) begin
            lo2 = 2 * longint'(rng_lo);
            hi2 = 2 * longint'(rng_hi);
        end else begin
            lo2 = 2 * lvl - wid;
            hi2 = 2 * lvl + wid;
        end
        x2 = 2 * longint'(smp);
        if (x2 <= lo2) begin
            q = 0;
        end else if (x2 > hi2) begin
            q = 255;
        end else begin
            d   = hi2 - lo2;
            num = 510 * (x2 - lo2) + d;   // round half up
            q   = num / (2 * d);
            if (q > 255) q = 255;
        end
        res.gray = q[GB-1:0];
        res.last = lst;
        has_res  = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Valid holds with a steady payload until accepted; the
    // acceptance edge is read from pre-edge values right after the clock.
    // ------------------------------------------------------------------------
    task automatic send_req(input logic act, input logic signed [SB-1:0] smp,
                            input logic lst, input logic pinned,
                            input logic [GB-1:0] pinned_gray);
        logic      has_res;
        gray_res_t res;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_sample <= smp;
        s_last   <= lst;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        map_sample(act, smp, lst, has_res, res);
        if (has_res) begin
            if (pinned) res.gray = pinned_gray;
            gray_due.push_back(res);
        end
    endtask

    // Register writes only once the block is idle: all grays back, then a
    // quiet stretch for any gather still in flight.
    task automatic set_window(input logic signed [LB-1:0] lvl,
                              input logic [WB-1:0] wid);
        s_valid <= 1'b0;
        while (gray_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= wl2g_pkg::REG_WINDOW_LEVEL;
        cfg_wdata <= lvl;
        @(posedge aclk);
        cfg_index <= wl2g_pkg::REG_WINDOW_WIDTH;
        cfg_wdata <= wid;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        win_level = lvl;
        win_width = wid;
    endtask

    // Random window; auto mode (both zero) comes up often since it is the
    // only mode where the gather pass matters.
    task automatic pick_window();
        logic signed [LB-1:0] lvl;
        logic [WB-1:0]        wid;
        case ($urandom_range(4))
            0:       lvl = 16'sh8000;
            1:       lvl = 16'sh7FFF;
            2:       lvl = '0;
            default: lvl = LB'($urandom);
        endcase
        case ($urandom_range(6))
            0:       wid = '0;
            1:       wid = 16'd1;
            2:       wid = 16'hFFFF;
            3:       wid = WB'($urandom_range(2, 64));
            default: wid = WB'($urandom);
        endcase
        if ($urandom_range(2) == 0) begin
            lvl = '0;
            wid = '0;
        end
        set_window(lvl, wid);
    endtask

    function automatic logic signed [SB-1:0] near(input logic signed [SB-1:0] ctr,
                                                  input int spread);
        int v;
        v = int'(ctr) + int'($urandom_range(2 * spread)) - spread;
        return v[SB-1:0];   // wraps at the extremes; still a legal sample
    endfunction

    // One image: a gather pass (sometimes skipped) then a convert pass.
    task automatic send_image();
        logic signed [SB-1:0] ctr;
        int                   spread, n_in, n_out;
        ctr = ((win_level == 0 && win_width == 0) || $urandom_range(1)) ?
              SB'($urandom) : win_level;
        case ($urandom_range(4))
            0:       spread = 2;
            1:       spread = 16;
            2:       spread = 300;
            3:       spread = 32768;
            default: spread = int'(win_width) / 2 + 3;   // hugs the bounds
        endcase
        n_in  = $urandom_range(0, 12);
        n_out = $urandom_range(1, 12);
        for (int i = 0; i < n_in; i++)
            send_req(wl2g_pkg::ACT_GATHER, near(ctr, spread), i == n_in - 1, 1'b0,
                     wl2g_pkg::GRAY_MIN);
        for (int i = 0; i < n_out; i++)
            send_req(wl2g_pkg::ACT_CONVERT, near(ctr, spread), i == n_out - 1, 1'b0,
                     wl2g_pkg::GRAY_MIN);
    endtask

    // Broken sequences: random action, flag and sample.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            send_req(1'($urandom_range(1)), SB'($urandom), 1'($urandom_range(1)), 1'b0,
                     wl2g_pkg::GRAY_MIN);
    endtask

    function automatic dir_row_t req_row(input logic act, input int smp, input logic lst,
                                         input logic pinned, input logic [GB-1:0] g);
        return '{kind: ROW_REQ, act: act, val: smp[SB-1:0], lst: lst, wid: '0,
                 pinned: pinned, gray: g};
    endfunction

    function automatic dir_row_t win_row(input int lvl, input int wid);
        return '{kind: ROW_WINDOW, act: wl2g_pkg::ACT_GATHER, val: lvl[SB-1:0], lst: 1'b0,
                 wid: wid[WB-1:0], pinned: 1'b0, gray: wl2g_pkg::GRAY_MIN};
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and receiver stall. Pre-edge values decide acceptance.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (gray_due.size() == 0) begin
                $error("gray: no request pending, got %0d", m_gray);
                fails++;
            end else begin
                got_due = gray_due.pop_front();
                if (m_gray !== got_due.gray) begin
                    $error("gray: expected %0d, got %0d", got_due.gray, m_gray);
                    fails++;
                end
                if (m_last_res !== got_due.last) begin
                    $error("last_res: expected %0d, got %0d", got_due.last, m_last_res);
                    fails++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a long run of cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("[window_level_to_gray8] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        dir_row_t dir_rows [$];
        int       phase_start;

        // reset state: auto mode with an empty 0..0 range
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 0, 1'b0, 1'b1, wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 1, 1'b1, 1'b1, wl2g_pkg::GRAY_MAX));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, -32768, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 32767, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MAX));
        // full-scale range from a two-sample gather pass
        dir_rows.push_back(req_row(wl2g_pkg::ACT_GATHER, -32768, 1'b0, 1'b0,
                                   wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_GATHER, 32767, 1'b1, 1'b0,
                                   wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, -32768, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 32767, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MAX));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 0, 1'b1, 1'b0, wl2g_pkg::GRAY_MIN));
        // a convert restarts the range; so does the gather after a last flag
        dir_rows.push_back(req_row(wl2g_pkg::ACT_GATHER, 100, 1'b0, 1'b0, wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_GATHER, 50, 1'b0, 1'b0, wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_GATHER, 300, 1'b0, 1'b0, wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_GATHER, 200, 1'b1, 1'b0, wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_GATHER, 400, 1'b0, 1'b0, wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_GATHER, 350, 1'b1, 1'b0, wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 350, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 400, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MAX));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 375, 1'b1, 1'b0,
                                   wl2g_pkg::GRAY_MIN));
        // empty window at the bottom of the range
        dir_rows.push_back(win_row(-32768, 0));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, -32768, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, -32767, 1'b1, 1'b1,
                                   wl2g_pkg::GRAY_MAX));
        // widest windows at both level extremes
        dir_rows.push_back(win_row(32767, 65535));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, -32768, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 32767, 1'b1, 1'b0,
                                   wl2g_pkg::GRAY_MIN));
        dir_rows.push_back(win_row(-32768, 65535));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 32767, 1'b0, 1'b1,
                                   wl2g_pkg::GRAY_MAX));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, -1, 1'b1, 1'b0, wl2g_pkg::GRAY_MIN));
        // odd width: bounds fall on half steps
        dir_rows.push_back(win_row(0, 1));
        dir_rows.push_back(req_row(wl2g_pkg::ACT_CONVERT, 0, 1'b1, 1'b0, wl2g_pkg::GRAY_MIN));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 0 pattern also covers the directed part
        idle_pct  = 30;
        stall_pct = 81;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WINDOW)
                set_window(dir_rows[i].val, dir_rows[i].wid);
            else
                send_req(dir_rows[i].act, dir_rows[i].val, dir_rows[i].lst,
                         dir_rows[i].pinned, dir_rows[i].gray);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin idle_pct = 30; stall_pct = 81; end
                1:       begin idle_pct = 81; stall_pct = 30; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            pick_window();
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(7) == 0) pick_window();
                if ($urandom_range(6) == 0)
                    send_noise();
                else
                    send_image();
            end
        end

        // drain: every gray back, then a tail for stray results
        s_valid <= 1'b0;
        while (gray_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0)
            $display("[window_level_to_gray8] OK");
        else
            $display("[window_level_to_gray8] ERROR");
        $finish;
    end

endmodule
